[sv/e2q_pkg.sv]
// e2q_pkg: shared constants, types and CORDIC arctangent table
// for the Euler-to-quaternion core. No dependencies.
`default_nettype none
package e2q_pkg;
  localparam int ANGLE_W = 16;
  localparam int Q15_W = 16;
  localparam int CORDIC_W = 34;
  localparam int ZACC_W = 33;
  localparam int ATAN_STEPS = 24;
  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [Q15_W-1:0] SAT_MAX = 16'sd32767;
  localparam logic signed [Q15_W-1:0] SAT_MIN = -16'sd32767;

  typedef logic signed [Q15_W-1:0] q15_t;

  typedef struct packed {
    q15_t c;
    q15_t s;
  } trig_t;

  function automatic logic signed [ZACC_W-1:0] atan_units(input int i);
    logic signed [ZACC_W-1:0] r;
    case (i)
      0: r = 33'sd536870912;
      1: r = 33'sd316933406;
      2: r = 33'sd167458907;
      3: r = 33'sd85004756;
      4: r = 33'sd42667331;
      5: r = 33'sd21354465;
      6: r = 33'sd10679838;
      7: r = 33'sd5340245;
      8: r = 33'sd2670163;
      9: r = 33'sd1335087;
      10: r = 33'sd667544;
      11: r = 33'sd333772;
      12: r = 33'sd166886;
      13: r = 33'sd83443;
      14: r = 33'sd41722;
      15: r = 33'sd20861;
      16: r = 33'sd10430;
      17: r = 33'sd5215;
      18: r = 33'sd2608;
      19: r = 33'sd1304;
      20: r = 33'sd652;
      21: r = 33'sd326;
      22: r = 33'sd163;
      default: r = 33'sd81;
    endcase
    return r;
  endfunction

  function automatic q15_t sat_round(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) return SAT_MAX;
    if (r < -34'sd32767) return SAT_MIN;
    return r[Q15_W-1:0];
  endfunction

  function automatic q15_t sat_round45(input logic signed [48:0] v);
    logic signed [48:0] r;
    r = (v + 49'sd536870912) >>> 30;
    if (r > 49'sd32767) return SAT_MAX;
    if (r < -49'sd32767) return SAT_MIN;
    return r[Q15_W-1:0];
  endfunction
endpackage
`default_nettype wire

[sv/e2q_cordic.sv]
// e2q_cordic: pipelined rotation-mode CORDIC, one register stage per step,
// gives cosine and sine of the half angle. Depends on e2q_pkg.
`default_nettype none
module e2q_cordic #(
  parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output e2q_pkg::trig_t trig
);
  localparam int N = (TRIG_ITERATIONS < e2q_pkg::ATAN_STEPS) ?
                     TRIG_ITERATIONS : e2q_pkg::ATAN_STEPS;
  logic signed [e2q_pkg::CORDIC_W-1:0] xs [0:N];
  logic signed [e2q_pkg::CORDIC_W-1:0] ys [0:N];
  logic signed [e2q_pkg::ZACC_W-1:0] zs [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= e2q_pkg::INV_GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= {{2{angle[e2q_pkg::ANGLE_W-1]}}, angle, 15'd0};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zs[i][e2q_pkg::ZACC_W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - e2q_pkg::atan_units(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + e2q_pkg::atan_units(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trig.c <= e2q_pkg::sat_round(xs[N]);
      trig.s <= e2q_pkg::sat_round(ys[N]);
    end
  end
endmodule
`default_nettype wire

[sv/e2q_combine.sv]
// e2q_combine: pipelined triple products and quaternion sums with rounding
// and saturation, three register stages. Depends on e2q_pkg.
`default_nettype none
module e2q_combine (
  input  wire logic clk,
  input  wire logic en,
  input  e2q_pkg::trig_t r,
  input  e2q_pkg::trig_t p,
  input  e2q_pkg::trig_t y,
  output e2q_pkg::q15_t w_o,
  output e2q_pkg::q15_t x_o,
  output e2q_pkg::q15_t y_o,
  output e2q_pkg::q15_t z_o
);
  logic signed [31:0] cc, sc, cs, ss;
  e2q_pkg::trig_t yd;
  logic signed [47:0] ccc, ccs, ssc, sss, scc, scs, csc, css;

  always_ff @(posedge clk) begin
    if (en) begin
      cc <= r.c * p.c;
      sc <= r.s * p.c;
      cs <= r.c * p.s;
      ss <= r.s * p.s;
      yd <= y;
      ccc <= cc * yd.c;
      ccs <= cc * yd.s;
      ssc <= ss * yd.c;
      sss <= ss * yd.s;
      scc <= sc * yd.c;
      scs <= sc * yd.s;
      csc <= cs * yd.c;
      css <= cs * yd.s;
      w_o <= e2q_pkg::sat_round45(49'(ccc) + 49'(sss));
      x_o <= e2q_pkg::sat_round45(49'(scc) - 49'(css));
      y_o <= e2q_pkg::sat_round45(49'(csc) + 49'(scs));
      z_o <= e2q_pkg::sat_round45(49'(ccs) - 49'(ssc));
    end
  end
endmodule
`default_nettype wire

[sv/euler_to_quaternion_core.sv]
// euler_to_quaternion_core: ZYX Euler angles to unit quaternion in Q1.15.
// Depends on e2q_pkg, e2q_cordic, e2q_combine.
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | roll_angle pitch_angle yaw_angle
//   out     | out_valid | out_stall | quat_w quat_x quat_y quat_z
// One transfer per cycle while no stalled result freezes the pipeline. The
// pipeline is the CORDIC input stage, its step stages and its rounding stage,
// plus two multiply stages and a sum stage.
// The whole pipeline freezes while a result waits stalled; in_stall
// follows out_stall only when the last stage holds a result.
// Reset clears the valid bits only.
`default_nettype none
module euler_to_quaternion_core #(
  parameter int TRIG_ITERATIONS = e2q_pkg::TRIG_ITERATIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  input  wire logic signed [15:0] yaw_angle,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  localparam int N = (TRIG_ITERATIONS < e2q_pkg::ATAN_STEPS) ?
                     TRIG_ITERATIONS : e2q_pkg::ATAN_STEPS;
  localparam int DEPTH = N + 5;

  logic [DEPTH-1:0] vld;
  logic en;
  e2q_pkg::trig_t tr, tp, ty;

  assign en = !(vld[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  e2q_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_roll (
    .clk(clk), .en(en), .angle(roll_angle), .trig(tr));
  e2q_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_pitch (
    .clk(clk), .en(en), .angle(pitch_angle), .trig(tp));
  e2q_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_yaw (
    .clk(clk), .en(en), .angle(yaw_angle), .trig(ty));

  e2q_combine u_comb (
    .clk(clk), .en(en), .r(tr), .p(tp), .y(ty),
    .w_o(quat_w), .x_o(quat_x), .y_o(quat_y), .z_o(quat_z));
endmodule
`default_nettype wire
